// ===== hdl/dsmd_pkg.sv =====
// Shared types and constants for the decimal(38,12) multiply/divide pipeline.
// No dependencies; used by every module under hdl.
`timescale 1ns / 1ps

package dsmd_pkg;

    localparam int DIV_W  = 128;
    localparam int NUM_W  = 2 * DIV_W;
    localparam int LIMB_W = 32;
    localparam int LIMBS  = DIV_W / LIMB_W;

    // 10^12, the fixed-point scale.
    localparam logic [DIV_W-1:0] SCALE = 128'd1000000000000;
    // 10^38 - 1, the largest magnitude that fits 38 digits.
    localparam logic [DIV_W-1:0] LIMIT = 128'h4B3B4CA85A86C47A098A223FFFFFFFFF;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_NULL = 2'd1,
        ST_OVF  = 2'd2,
        ST_DIVZ = 2'd3
    } status_t;

    // Sideband that travels with each request through the pipeline.
    typedef struct packed {
        logic    valid;
        logic    neg;
        status_t status;
    } tag_t;

endpackage

// ===== hdl/dsmd_mul.sv =====
// Three-stage 128 x 128 unsigned multiplier built from 32 x 32 partial products.
// Depends on dsmd_pkg for widths and the request tag type.
`timescale 1ns / 1ps

module dsmd_mul #(
    parameter int W = dsmd_pkg::DIV_W
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  dsmd_pkg::tag_t       i_tag,
    input  logic [W-1:0]         i_x,
    input  logic [W-1:0]         i_y,
    input  logic [W-1:0]         i_d,
    output dsmd_pkg::tag_t       o_tag,
    output logic [2*W-1:0]       o_prod,
    output logic [W-1:0]         o_d
);

    localparam int LW = dsmd_pkg::LIMB_W;
    localparam int NL = W / LW;
    localparam int RW = W + 2 * LW;

    dsmd_pkg::tag_t         tag1_reg, tag2_reg, tag3_reg;
    logic [W-1:0]           d1_reg, d2_reg, d3_reg;
    logic [2*LW-1:0]        pp_reg [NL][NL];
    logic [2*LW-1:0]        pp_next [NL][NL];
    logic [RW-1:0]          row_reg [NL];
    logic [RW-1:0]          row_next [NL];
    logic [2*W-1:0]         prod_reg, prod_next;

    always_comb begin
        for (int i = 0; i < NL; i++) begin
            for (int j = 0; j < NL; j++) begin
                pp_next[i][j] = i_x[LW*i +: LW] * i_y[LW*j +: LW];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NL; i++) begin
            row_next[i] = '0;
            for (int j = 0; j < NL; j++) begin
                row_next[i] = row_next[i] + (RW'(pp_reg[i][j]) << (LW * j));
            end
        end
    end

    always_comb begin
        prod_next = '0;
        for (int i = 0; i < NL; i++) begin
            prod_next = prod_next + ((2*W)'(row_reg[i]) << (LW * i));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg.valid <= 1'b0;
            tag2_reg.valid <= 1'b0;
            tag3_reg.valid <= 1'b0;
        end else if (en) begin
            tag1_reg <= i_tag;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pp_reg   <= pp_next;
            d1_reg   <= i_d;
            row_reg  <= row_next;
            d2_reg   <= d1_reg;
            prod_reg <= prod_next;
            d3_reg   <= d2_reg;
        end
    end

    assign o_tag  = tag3_reg;
    assign o_prod = prod_reg;
    assign o_d    = d3_reg;

endmodule

// ===== hdl/dsmd_cell.sv =====
// One restoring-division cell: develops one quotient bit and passes it on.
// Depends on dsmd_pkg for the request tag type.
`timescale 1ns / 1ps

module dsmd_cell #(
    parameter int W = dsmd_pkg::DIV_W
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  dsmd_pkg::tag_t  i_tag,
    input  logic [W-1:0]    i_rem,
    input  logic [W-1:0]    i_nq,
    input  logic [W-1:0]    i_d,
    output dsmd_pkg::tag_t  o_tag,
    output logic [W-1:0]    o_rem,
    output logic [W-1:0]    o_nq,
    output logic [W-1:0]    o_d
);

    // The shift register nq holds unconsumed dividend bits at the top and
    // finished quotient bits at the bottom.
    dsmd_pkg::tag_t tag_reg;
    logic [W-1:0]   rem_reg, rem_next;
    logic [W-1:0]   nq_reg, nq_next;
    logic [W-1:0]   d_reg;
    logic [W:0]     trial;
    logic [W+1:0]   diff;
    logic           fits;

    always_comb begin
        trial    = {i_rem, i_nq[W-1]};
        diff     = {1'b0, trial} - {2'b00, i_d};
        fits     = ~diff[W+1];
        rem_next = fits ? diff[W-1:0] : trial[W-1:0];
        nq_next  = {i_nq[W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg.valid <= 1'b0;
        end else if (en) begin
            tag_reg <= i_tag;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            nq_reg  <= nq_next;
            d_reg   <= i_d;
        end
    end

    assign o_tag = tag_reg;
    assign o_rem = rem_reg;
    assign o_nq  = nq_reg;
    assign o_d   = d_reg;

endmodule

// ===== hdl/decimal38_scaled_mul_div.sv =====
// Top level of the decimal(38,12) multiply/divide pipeline.
// Depends on dsmd_pkg, dsmd_mul and dsmd_cell.
`timescale 1ns / 1ps

// Usage
// Each request on the s_ channel carries two signed 128-bit operands scaled
// by 10^12, their null flags and an operation select (multiply or divide).
// Each request yields exactly one response on the m_ channel: the 128-bit
// scaled result and a status (ok, null, overflow, divide by zero).
// Both operations reduce to one division of a 256-bit value: multiply divides
// |a|*|b| by 10^12 and divide divides |a|*10^12 by |b|. The shared multiplier
// takes three stages, then a row of 128 division cells yields one quotient
// bit per cell. The cells advance every cycle unless the skid register is
// full, so one request is taken per cycle and one response leaves per cycle
// at steady state while the receiver does not stall.
// When the receiver stalls, the pipeline drains its last result into a skid
// register and then holds; s_tready is registered and drops only while the
// skid register is full. Reset empties the pipeline and deasserts both valids.
module decimal38_scaled_mul_div (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // a_hi [63:0], a_lo [127:64], b_hi [191:128], b_lo [255:192]
    input  logic [255:0] s_tdata,
    // mode [0], a_is_null [1], b_is_null [2]
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // result_hi [63:0], result_lo [127:64]
    output logic [127:0] m_tdata,
    // status [1:0]
    output logic [1:0]   m_tuser
);

    localparam int W     = dsmd_pkg::DIV_W;
    localparam int NCELL = dsmd_pkg::DIV_W;

    logic en;
    logic skid_valid_reg, skid_valid_next;

    // Input decode and absolute values.
    logic [W-1:0]   a_in, b_in, a_abs, b_abs;
    logic           a_neg, b_neg, mode, a_null, b_null;
    dsmd_pkg::tag_t tag_in;

    always_comb begin
        mode   = s_tuser[0];
        a_null = s_tuser[1];
        b_null = s_tuser[2];
        a_in   = {s_tdata[63:0], s_tdata[127:64]};
        b_in   = {s_tdata[191:128], s_tdata[255:192]};
        a_neg  = a_in[W-1];
        b_neg  = b_in[W-1];
        a_abs  = a_neg ? (~a_in + 1'b1) : a_in;
        b_abs  = b_neg ? (~b_in + 1'b1) : b_in;
        tag_in.valid = s_tvalid;
        tag_in.neg   = a_neg ^ b_neg;
        if (a_null || b_null) begin
            tag_in.status = dsmd_pkg::ST_NULL;
        end else if (mode && (b_in == '0)) begin
            tag_in.status = dsmd_pkg::ST_DIVZ;
        end else begin
            tag_in.status = dsmd_pkg::ST_OK;
        end
    end

    dsmd_pkg::tag_t tag0_reg;
    logic [W-1:0]   x0_reg, y0_reg, d0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag0_reg.valid <= 1'b0;
        end else if (en) begin
            tag0_reg <= tag_in;
        end
    end

    // Multiply uses 10^12 as the divisor; divide scales a by 10^12 instead.
    always_ff @(posedge aclk) begin
        if (en) begin
            x0_reg <= a_abs;
            y0_reg <= mode ? dsmd_pkg::SCALE : b_abs;
            d0_reg <= mode ? b_abs : dsmd_pkg::SCALE;
        end
    end

    dsmd_pkg::tag_t mul_tag;
    logic [2*W-1:0] mul_prod;
    logic [W-1:0]   mul_d;

    dsmd_mul #(.W(W)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .i_tag   (tag0_reg),
        .i_x     (x0_reg),
        .i_y     (y0_reg),
        .i_d     (d0_reg),
        .o_tag   (mul_tag),
        .o_prod  (mul_prod),
        .o_d     (mul_d)
    );

    // If the upper half of the product already reaches the divisor, the
    // quotient needs more than 128 bits and is an overflow. Otherwise the
    // upper half is a valid starting remainder for the cells.
    dsmd_pkg::tag_t pre_tag_reg, pre_tag_next;
    logic [W-1:0]   pre_rem_reg, pre_rem_next;
    logic [W-1:0]   pre_nq_reg, pre_d_reg;
    logic           pre_big;

    always_comb begin
        pre_big      = mul_prod[2*W-1:W] >= mul_d;
        pre_tag_next = mul_tag;
        if (pre_big && (mul_tag.status == dsmd_pkg::ST_OK)) begin
            pre_tag_next.status = dsmd_pkg::ST_OVF;
        end
        pre_rem_next = pre_big ? '0 : mul_prod[2*W-1:W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_tag_reg.valid <= 1'b0;
        end else if (en) begin
            pre_tag_reg <= pre_tag_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pre_rem_reg <= pre_rem_next;
            pre_nq_reg  <= mul_prod[W-1:0];
            pre_d_reg   <= mul_d;
        end
    end

    // Row of division cells, one quotient bit each.
    dsmd_pkg::tag_t c_tag [NCELL+1];
    logic [W-1:0]   c_rem [NCELL+1];
    logic [W-1:0]   c_nq  [NCELL+1];
    logic [W-1:0]   c_d   [NCELL+1];

    assign c_tag[0] = pre_tag_reg;
    assign c_rem[0] = pre_rem_reg;
    assign c_nq[0]  = pre_nq_reg;
    assign c_d[0]   = pre_d_reg;

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        dsmd_cell #(.W(W)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .i_tag   (c_tag[k]),
            .i_rem   (c_rem[k]),
            .i_nq    (c_nq[k]),
            .i_d     (c_d[k]),
            .o_tag   (c_tag[k+1]),
            .o_rem   (c_rem[k+1]),
            .o_nq    (c_nq[k+1]),
            .o_d     (c_d[k+1])
        );
    end

    // Range check on the finished quotient. The remainder and divisor of the
    // last cell are not needed.
    dsmd_pkg::tag_t fin_tag_reg, fin_tag_next;
    logic [W-1:0]   fin_q_reg;

    always_comb begin
        fin_tag_next = c_tag[NCELL];
        if ((c_nq[NCELL] > dsmd_pkg::LIMIT) && (c_tag[NCELL].status == dsmd_pkg::ST_OK)) begin
            fin_tag_next.status = dsmd_pkg::ST_OVF;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_tag_reg.valid <= 1'b0;
        end else if (en) begin
            fin_tag_reg <= fin_tag_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fin_q_reg <= c_nq[NCELL];
        end
    end

    // Final formatting: sign, null pattern, zero on errors.
    logic [W-1:0] res;

    always_comb begin
        case (fin_tag_reg.status)
            dsmd_pkg::ST_NULL: res = {1'b1, {(W-1){1'b0}}};
            dsmd_pkg::ST_OK:   res = fin_tag_reg.neg ? (~fin_q_reg + 1'b1) : fin_q_reg;
            default:           res = '0;
        endcase
    end

    // Output register with a skid register behind it.
    logic         out_valid_reg, out_valid_next;
    logic [W-1:0] out_data_reg, out_data_next;
    logic [1:0]   out_stat_reg, out_stat_next;
    logic [W-1:0] skid_data_reg, skid_data_next;
    logic [1:0]   skid_stat_reg, skid_stat_next;
    logic         last_valid;

    assign en         = ~skid_valid_reg;
    assign last_valid = fin_tag_reg.valid & en;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_stat_next   = out_stat_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        skid_stat_next  = skid_stat_reg;
        if (out_valid_reg && !m_tready) begin
            if (last_valid) begin
                skid_valid_next = 1'b1;
                skid_data_next  = res;
                skid_stat_next  = fin_tag_reg.status;
            end
        end else if (skid_valid_reg) begin
            out_valid_next  = 1'b1;
            out_data_next   = skid_data_reg;
            out_stat_next   = skid_stat_reg;
            skid_valid_next = 1'b0;
        end else begin
            out_valid_next = last_valid;
            out_data_next  = res;
            out_stat_next  = fin_tag_reg.status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        out_stat_reg  <= out_stat_next;
        skid_data_reg <= skid_data_next;
        skid_stat_reg <= skid_stat_next;
    end

    assign s_tready = en;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data_reg[W/2-1:0], out_data_reg[W-1:W/2]};
    assign m_tuser  = out_stat_reg;

`ifndef ASSERT_OFF
    // The skid register only fills while the output is stalled.
    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(m_tvalid && !m_tready))
        else $error("skid register filled without an output stall");

    // An error response always carries a zero value.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == dsmd_pkg::ST_OVF || m_tuser == dsmd_pkg::ST_DIVZ)
        |-> m_tdata == '0)
        else $error("error response with nonzero data");

    // A null response carries the minimum 128-bit value.
    a_null_min: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == dsmd_pkg::ST_NULL)
        |-> (m_tdata[63:0] == 64'h8000000000000000) && (m_tdata[127:64] == '0))
        else $error("null response with wrong data");

    // The skid register drains as soon as the output is free.
    a_skid_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && !(m_tvalid && !m_tready) |=> !skid_valid_reg)
        else $error("skid register did not drain");
`endif

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for decimal38_scaled_mul_div.
// Depends on dsmd_pkg and the block; drives requests and checks every response against a predictor.
`timescale 1ns / 1ps

// Expected response and the queue of responses still owed by the block.
class decimal_scoreboard;
    typedef struct {
        logic [63:0]       res_hi;
        logic [63:0]       res_lo;
        dsmd_pkg::status_t status;
    } decimal_result_t;

    decimal_result_t owed_q[$];
    int              mismatches;

    // Works out the exact decimal(38,12) product or quotient of one request.
    function void note_request(logic mode, logic [127:0] a, logic [127:0] b,
                               logic a_null, logic b_null);
        localparam logic [255:0] TEN12 = 256'd1000000000000;
        localparam logic [255:0] MAX38 = 256'd99999999999999999999999999999999999999;
        decimal_result_t r;
        logic            a_neg, b_neg;
        logic [127:0]    mag_a, mag_b, mag_r;
        logic [255:0]    wide;
        a_neg = a[127];
        b_neg = b[127];
        mag_a = a_neg ? -a : a;
        mag_b = b_neg ? -b : b;
        if (a_null || b_null) begin
            r = '{64'h8000_0000_0000_0000, 64'd0, dsmd_pkg::ST_NULL};
        end else if (mode && mag_b == 0) begin
            r = '{64'd0, 64'd0, dsmd_pkg::ST_DIVZ};
        end else begin
            if (!mode)
                wide = ({128'd0, mag_a} * {128'd0, mag_b}) / TEN12;
            else
                wide = ({128'd0, mag_a} * TEN12) / {128'd0, mag_b};
            if (wide > MAX38) begin
                r = '{64'd0, 64'd0, dsmd_pkg::ST_OVF};
            end else begin
                mag_r = wide[127:0];
                if (a_neg != b_neg)
                    mag_r = -mag_r;
                r = '{mag_r[127:64], mag_r[63:0], dsmd_pkg::ST_OK};
            end
        end
        owed_q = {owed_q, r};
    endfunction

    function void check_response(logic [63:0] hi, logic [63:0] lo, logic [1:0] st);
        decimal_result_t e;
        if (owed_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected response hi=%h lo=%h status=%0d", hi, lo, st);
            return;
        end
        e = owed_q.pop_front();
        if (hi !== e.res_hi || lo !== e.res_lo || st !== e.status) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected hi=%h lo=%h status=%0d, got hi=%h lo=%h status=%0d",
                         e.res_hi, e.res_lo, e.status, hi, lo, st);
        end
    endfunction

    function int owed();
        return owed_q.size();
    endfunction
endclass

module tb_top;

    localparam int RANDOM_REQUESTS = 1030;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int DRAIN_CYCLES    = 200;
    localparam logic MODE_MUL = 1'b0;
    localparam logic MODE_DIV = 1'b1;

    localparam logic [127:0] MAX_POS = {1'b0, {127{1'b1}}};
    localparam logic [127:0] MIN_NEG = {1'b1, 127'd0};
    localparam logic [127:0] ONE_38  = 128'd99999999999999999999999999999999999999;
    localparam logic [127:0] UNIT    = 128'd1000000000000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [255:0] s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic [1:0]   m_tuser;

    decimal_scoreboard sb = new();
    int  idle_cycles = 0;
    int  burst_left = 0;

    always #5 aclk = ~aclk;

    decimal38_scaled_mul_div u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // The receiver runs in phases: some with no stalls at all, others that stall
    // at random with a density picked for the phase.
    int stall_pct = 0;
    int phase_left = 0;
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_response(m_tdata[63:0], m_tdata[127:64], m_tuser);
        if (phase_left == 0) begin
            phase_left <= $urandom_range(20, 300);
            stall_pct  <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 90);
        end else begin
            phase_left <= phase_left - 1;
        end
        m_tready <= ($urandom_range(1, 100) > stall_pct);
    end

    // Watchdog on cycles in which neither channel moves a request or response.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Present one request and hold it until accepted; afterwards the sender
    // may pause, so gaps land on every stage of the pipeline.
    task automatic send_request(logic mode, logic [127:0] a, logic [127:0] b,
                                logic a_null, logic b_null);
        s_tvalid <= 1'b1;
        s_tdata  <= {b[63:0], b[127:64], a[63:0], a[127:64]};
        s_tuser  <= {b_null, a_null, mode};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note_request(mode, a, b, a_null, b_null);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 40);
            if ($urandom_range(0, 3) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    endtask

    // Operand with a random magnitude spread across the whole width, so small,
    // in-range and oversized values all occur.
    function automatic logic [127:0] rand_operand();
        logic [127:0] v;
        v = {$urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(0, 9))
            0: return v;
            1: return '0;
            2: return ($urandom_range(0, 1)) ? MAX_POS : MIN_NEG;
            3: return UNIT;
            default: begin
                v = v >> $urandom_range(40, 127);
                return ($urandom_range(0, 1)) ? -v : v;
            end
        endcase
    endfunction

    initial begin
        logic m, an, bn;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Null operands win over everything, in both modes.
        send_request(MODE_MUL, UNIT, UNIT, 1'b1, 1'b0);
        send_request(MODE_DIV, UNIT, 128'd0, 1'b0, 1'b1);
        send_request(MODE_DIV, MAX_POS, MIN_NEG, 1'b1, 1'b1);
        // Plain values and sign combinations.
        send_request(MODE_MUL, UNIT * 3, -(UNIT * 7), 1'b0, 1'b0);
        send_request(MODE_DIV, -(UNIT * 22), -(UNIT * 7), 1'b0, 1'b0);
        send_request(MODE_DIV, UNIT, UNIT * 3, 1'b0, 1'b0);
        // Division by zero, also with a zero dividend.
        send_request(MODE_DIV, UNIT, 128'd0, 1'b0, 1'b0);
        send_request(MODE_DIV, 128'd0, 128'd0, 1'b0, 1'b0);
        // Tiny negative product truncates to zero, which must come back positive.
        send_request(MODE_MUL, -128'd1, 128'd1, 1'b0, 1'b0);
        send_request(MODE_DIV, -128'd1, MAX_POS, 1'b0, 1'b0);
        // Largest 38-digit values: exact limit and just past it.
        send_request(MODE_MUL, ONE_38, UNIT, 1'b0, 1'b0);
        send_request(MODE_MUL, -ONE_38, UNIT, 1'b0, 1'b0);
        send_request(MODE_MUL, ONE_38 + 1, UNIT, 1'b0, 1'b0);
        send_request(MODE_DIV, ONE_38, UNIT, 1'b0, 1'b0);
        send_request(MODE_DIV, ONE_38, 128'd1, 1'b0, 1'b0);
        // Operands beyond 38 digits and the full 128-bit extremes.
        send_request(MODE_MUL, MAX_POS, MAX_POS, 1'b0, 1'b0);
        send_request(MODE_MUL, MIN_NEG, MIN_NEG, 1'b0, 1'b0);
        send_request(MODE_MUL, MIN_NEG, 128'd1, 1'b0, 1'b0);
        send_request(MODE_DIV, MIN_NEG, MIN_NEG, 1'b0, 1'b0);
        send_request(MODE_DIV, MAX_POS, MIN_NEG, 1'b0, 1'b0);
        send_request(MODE_MUL, 128'd0, MIN_NEG, 1'b0, 1'b0);
        send_request(MODE_DIV, 128'd0, -128'd1, 1'b0, 1'b0);

        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            m  = $urandom_range(0, 1);
            an = ($urandom_range(0, 15) == 0);
            bn = ($urandom_range(0, 15) == 0);
            send_request(m, rand_operand(), rand_operand(), an, bn);
        end
        s_tvalid <= 1'b0;

        while (sb.owed() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.mismatches == 0 && sb.owed() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/dsmd_pkg.sv
hdl/dsmd_mul.sv
hdl/dsmd_cell.sv
hdl/decimal38_scaled_mul_div.sv
dv/tb_top.sv
